### hdl/bst_pkg.sv
// Shared constants, item types and state encoding of the binary search table.
package bst_pkg;

  localparam int DEPTH      = 1024;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);

  localparam int INDEX_W = 10;
  localparam int COUNT_W = 5;

  // Depth of the command queue between the front and the back.
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef struct packed {
    logic                         op;
    logic [INDEX_W-1:0]           index;
    logic signed [DATA_WIDTH-1:0] value;
    logic [INDEX_W-1:0]           search_low;
    logic [INDEX_W-1:0]           search_high;
  } in_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] position;
    logic [COUNT_W-1:0] compare_count;
  } out_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    logic                         is_search;
    logic [ADDR_W-1:0]            addr;
    logic signed [DATA_WIDTH-1:0] key;
    logic [ADDR_W-1:0]            lo;
    logic [ADDR_W-1:0]            hi;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_EVAL
  } state_t;

endpackage

### hdl/bst_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module bst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/bst_front.sv
// Front part: accepts items, classifies them into commands and queues them.
module bst_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bst_pkg::in_t  cmd,
  output logic          full,
  output logic          q_valid,
  output bst_pkg::cmd_t q_cmd,
  input  logic          q_take
);

  bst_pkg::cmd_t               slots [bst_pkg::QDEPTH];
  logic [bst_pkg::QPTR_W-1:0]  wr_ptr;
  logic [bst_pkg::QPTR_W-1:0]  rd_ptr;
  logic [bst_pkg::QCNT_W-1:0]  count;
  bst_pkg::cmd_t               classified;
  logic                        do_push;
  logic                        do_pop;

  // Indexes are taken modulo the table depth.
  always_comb begin
    classified.is_search = (cmd.op == bst_pkg::OP_SEARCH);
    classified.addr      = cmd.index[bst_pkg::ADDR_W-1:0];
    classified.key       = cmd.value;
    classified.lo        = cmd.search_low[bst_pkg::ADDR_W-1:0];
    classified.hi        = cmd.search_high[bst_pkg::ADDR_W-1:0];
  end

  assign full    = (count == bst_pkg::QCNT_W'(bst_pkg::QDEPTH));
  assign q_valid = (count != '0);
  assign q_cmd   = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == bst_pkg::QPTR_W'(bst_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == bst_pkg::QPTR_W'(bst_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hdl/bst_back.sv
// Back part: table storage, the probe sequencer and the result register.
module bst_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  bst_pkg::cmd_t q_cmd,
  output logic          q_take,
  output logic          res_valid,
  output bst_pkg::out_t result,
  input  logic          pop
);

  bst_pkg::state_t                      state, state_next;
  logic signed [bst_pkg::DATA_WIDTH-1:0] key, key_next;
  logic [bst_pkg::ADDR_W-1:0]           lo, lo_next;
  logic [bst_pkg::ADDR_W-1:0]           hi, hi_next;
  logic [bst_pkg::COUNT_W-1:0]          count, count_next;
  logic [bst_pkg::COUNT_W-1:0]          count_inc;
  logic [bst_pkg::ADDR_W:0]             sum;
  logic [bst_pkg::ADDR_W-1:0]           mid;
  logic signed [bst_pkg::DATA_WIDTH-1:0] rd_lo, rd_hi, rd_mid;
  logic                                 wr_en;
  logic                                 slot_free;
  logic                                 fin;
  logic                                 fin_found;
  logic [bst_pkg::ADDR_W-1:0]           fin_pos;
  logic [bst_pkg::COUNT_W-1:0]          fin_count;

  assign sum       = {1'b0, lo} + {1'b0, hi};
  assign mid       = sum[bst_pkg::ADDR_W:1];
  assign count_inc = (count == '1) ? count : count + 1'b1;
  assign slot_free = !res_valid || pop;

  // Three copies of the table so that the low, high and middle entries
  // of one probe level are read in the same cycle.
  bst_ram #(.WIDTH(bst_pkg::DATA_WIDTH), .DEPTH(bst_pkg::DEPTH)) u_ram_lo (
    .clk(clk), .we(wr_en), .waddr(q_cmd.addr), .wdata(q_cmd.key),
    .raddr(lo), .rdata(rd_lo)
  );

  bst_ram #(.WIDTH(bst_pkg::DATA_WIDTH), .DEPTH(bst_pkg::DEPTH)) u_ram_hi (
    .clk(clk), .we(wr_en), .waddr(q_cmd.addr), .wdata(q_cmd.key),
    .raddr(hi), .rdata(rd_hi)
  );

  bst_ram #(.WIDTH(bst_pkg::DATA_WIDTH), .DEPTH(bst_pkg::DEPTH)) u_ram_mid (
    .clk(clk), .we(wr_en), .waddr(q_cmd.addr), .wdata(q_cmd.key),
    .raddr(mid), .rdata(rd_mid)
  );

  always_comb begin
    state_next = state;
    key_next   = key;
    lo_next    = lo;
    hi_next    = hi;
    count_next = count;
    q_take     = 1'b0;
    wr_en      = 1'b0;
    fin        = 1'b0;
    fin_found  = 1'b0;
    fin_pos    = '0;
    fin_count  = count;
    case (state)
      bst_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_take = 1'b1;
          if (q_cmd.is_search) begin
            key_next   = q_cmd.key;
            lo_next    = q_cmd.lo;
            hi_next    = q_cmd.hi;
            count_next = '0;
            state_next = bst_pkg::ST_PROBE;
          end else begin
            wr_en = 1'b1;
          end
        end
      end
      bst_pkg::ST_PROBE: begin
        // An empty range ends the search without counting a comparison.
        if (lo > hi) begin
          fin = 1'b1;
        end else begin
          state_next = bst_pkg::ST_EVAL;
        end
      end
      bst_pkg::ST_EVAL: begin
        count_next = count_inc;
        fin_count  = count_inc;
        if (key < rd_lo || key > rd_hi) begin
          fin = 1'b1;
        end else if (key == rd_mid) begin
          fin       = 1'b1;
          fin_found = 1'b1;
          fin_pos   = mid;
        end else if (key == rd_lo) begin
          fin       = 1'b1;
          fin_found = 1'b1;
          fin_pos   = lo;
        end else if (key == rd_hi) begin
          fin       = 1'b1;
          fin_found = 1'b1;
          fin_pos   = hi;
        end else if (key < rd_mid) begin
          if (mid == lo) begin
            fin = 1'b1;
          end else begin
            hi_next    = mid - bst_pkg::ADDR_W'(1);
            state_next = bst_pkg::ST_PROBE;
          end
        end else begin
          lo_next    = mid + bst_pkg::ADDR_W'(1);
          state_next = bst_pkg::ST_PROBE;
        end
      end
      default: begin
        state_next = bst_pkg::ST_IDLE;
      end
    endcase
    // A finished search waits in place while the result register is occupied;
    // the read addresses stay put, so the read data stays valid.
    if (fin) begin
      if (slot_free) begin
        state_next = bst_pkg::ST_IDLE;
      end else begin
        state_next = state;
        count_next = count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bst_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    key   <= key_next;
    lo    <= lo_next;
    hi    <= hi_next;
    count <= count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fin && slot_free) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin && slot_free) begin
      result.found         <= fin_found;
      result.position      <= bst_pkg::INDEX_W'(fin_pos);
      result.compare_count <= fin_count;
    end
  end

endmodule

### hdl/binary_search_table_top.sv
// Top level of the binary search table: front queue, probe engine and result port.
//
//   channel   direction  handshake           payload
//   cmd       in         push / full         bst_pkg::in_t  (op, index, value, range)
//   result    out        pop / empty         bst_pkg::out_t (found, position, count)
//
// A write item is written to all three table copies as it leaves the queue.
// A search item is loaded in the idle state; each probe level then has an address
// state, then a compare state on the registered reads of three table copies; the
// back takes no new item until the search ends and its result is stored.
// Reset is synchronous; the table itself is not cleared and reads are only
// defined for written entries. The queue keeps taking items while a result waits.
module binary_search_table_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bst_pkg::in_t  cmd,
  output logic          full,
  output logic          empty,
  input  logic          pop,
  output bst_pkg::out_t result
);

  logic          q_valid;
  logic          q_take;
  bst_pkg::cmd_t q_cmd;
  logic          res_valid;

  bst_front u_front (
    .clk(clk), .rst(rst), .push(push), .cmd(cmd), .full(full),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_take(q_take)
  );

  bst_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_cmd(q_cmd), .q_take(q_take),
    .res_valid(res_valid), .result(result), .pop(pop)
  );

  assign empty = !res_valid;

  // A search that misses reports position zero.
  a_miss_pos_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && !result.found |-> result.position == '0)
    else $error("not-found result with nonzero position");

  // A hit needs at least one comparison.
  a_hit_counted: assert property (@(posedge clk) disable iff (rst)
    !empty && result.found |-> result.compare_count != '0)
    else $error("found result with zero comparisons");

  // An accepted item is visible to the back on the following cycle.
  a_queue_holds: assert property (@(posedge clk) disable iff (rst)
    push && !full |=> q_valid)
    else $error("accepted item missing from the command queue");

  // The back only takes a command the queue presents.
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    q_take |-> q_valid)
    else $error("command taken from an empty queue");

endmodule

### test/tb_binary_search_table_top.sv
// Testbench for the binary search table: sorted-run loads, range searches and result checks.
`timescale 1ns / 100ps

module tb_binary_search_table_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 50;
  localparam int ITEM_TARGET = 900;
  localparam int COUNT_MAX   = (1 << bst_pkg::COUNT_W) - 1;

  localparam logic signed [bst_pkg::DATA_WIDTH-1:0] WORD_MIN =
    {1'b1, {(bst_pkg::DATA_WIDTH-1){1'b0}}};
  localparam logic signed [bst_pkg::DATA_WIDTH-1:0] WORD_MAX =
    {1'b0, {(bst_pkg::DATA_WIDTH-1){1'b1}}};
  localparam longint LONG_MIN = -(longint'(1) << (bst_pkg::DATA_WIDTH - 1));
  localparam longint LONG_MAX = (longint'(1) << (bst_pkg::DATA_WIDTH - 1)) - 1;

  class result_scoreboard;
    logic signed [bst_pkg::DATA_WIDTH-1:0] entries [bst_pkg::DEPTH];
    bit                                    written [bst_pkg::DEPTH];
    bst_pkg::out_t                         expected_q [$];
    int                                    errors;

    function new();
      errors = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    // Walks the probe levels of one search. clean drops to 0 when any probe
    // level would address an entry that has not been written yet.
    function bst_pkg::out_t predict(input bst_pkg::in_t c, output bit clean);
      bst_pkg::out_t                         r;
      int                                    lo;
      int                                    hi;
      int                                    mid;
      int                                    count;
      logic signed [bst_pkg::DATA_WIDTH-1:0] key;
      logic signed [bst_pkg::DATA_WIDTH-1:0] vl;
      logic signed [bst_pkg::DATA_WIDTH-1:0] vh;
      logic signed [bst_pkg::DATA_WIDTH-1:0] vm;
      r     = '0;
      clean = 1'b1;
      key   = c.value;
      lo    = int'(c.search_low);
      hi    = int'(c.search_high);
      count = 0;
      while (1) begin
        mid = (lo + hi) / 2;
        if (!written[lo % bst_pkg::DEPTH] || !written[hi % bst_pkg::DEPTH] ||
            !written[mid % bst_pkg::DEPTH]) begin
          clean = 1'b0;
        end
        if (lo > hi) break;
        vl = entries[lo];
        vh = entries[hi];
        if (count < COUNT_MAX) count++;
        if (key < vl || key > vh) break;
        vm = entries[mid];
        if (key == vm) begin
          r.found    = 1'b1;
          r.position = bst_pkg::INDEX_W'(mid);
          break;
        end
        if (key == vl) begin
          r.found    = 1'b1;
          r.position = bst_pkg::INDEX_W'(lo);
          break;
        end
        if (key == vh) begin
          r.found    = 1'b1;
          r.position = bst_pkg::INDEX_W'(hi);
          break;
        end
        if (key < vm) begin
          if (mid == lo) break;
          hi = mid - 1;
        end else begin
          lo = mid + 1;
        end
      end
      r.compare_count = bst_pkg::COUNT_W'(count);
      return r;
    endfunction

    function void note_item(input bst_pkg::in_t c);
      bit clean;
      if (c.op == bst_pkg::OP_WRITE) begin
        entries[c.index] = c.value;
        written[c.index] = 1'b1;
      end else begin
        expected_q.push_back(predict(c, clean));
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(input bst_pkg::out_t got);
      bst_pkg::out_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result found=%0d position=%0d count=%0d",
                         got.found, got.position, got.compare_count));
      end else begin
        want = expected_q.pop_front();
        if (got.found !== want.found)
          report($sformatf("found %0d, want %0d", got.found, want.found));
        if (got.position !== want.position)
          report($sformatf("position %0d, want %0d", got.position, want.position));
        if (got.compare_count !== want.compare_count)
          report($sformatf("compare_count %0d, want %0d", got.compare_count,
                           want.compare_count));
      end
    endtask
  endclass

  logic           clk;
  logic           rst;
  logic           push;
  bst_pkg::in_t   cmd;
  logic           full;
  logic           empty;
  logic           pop;
  bst_pkg::out_t  result;

  result_scoreboard sb;
  int    cycles;
  int    items_sent;
  bit    steady;

  binary_search_table_top dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .cmd    (cmd),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int draw_gap();
    return steady ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic bst_pkg::in_t make_write(input int idx,
                                              input logic signed [bst_pkg::DATA_WIDTH-1:0] v);
    bst_pkg::in_t c;
    c.op          = bst_pkg::OP_WRITE;
    c.index       = bst_pkg::INDEX_W'(idx);
    c.value       = v;
    c.search_low  = bst_pkg::INDEX_W'($urandom);
    c.search_high = bst_pkg::INDEX_W'($urandom);
    return c;
  endfunction

  function automatic bst_pkg::in_t make_search(
    input logic signed [bst_pkg::DATA_WIDTH-1:0] key, input int lo, input int hi);
    bst_pkg::in_t c;
    c.op          = bst_pkg::OP_SEARCH;
    c.index       = bst_pkg::INDEX_W'($urandom);
    c.value       = key;
    c.search_low  = bst_pkg::INDEX_W'(lo);
    c.search_high = bst_pkg::INDEX_W'(hi);
    return c;
  endfunction

  // Entered just after a rising edge; returns just after the edge that took the item.
  task automatic send_item(input bst_pkg::in_t c);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd  <= c;
    push <= 1'b1;
    do @(posedge clk); while (full);
    sb.note_item(c);
    items_sent++;
  endtask

  // Drops push before waiting, so the last item is not taken again.
  task automatic wait_drained();
    @(negedge clk);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Loads a nondecreasing run of values into consecutive entries.
  task automatic load_sorted_run(input int base, input int len);
    longint      cur;
    longint      highest;
    longint      span;
    int unsigned step;
    bit [63:0]   r;
    int          i;
    case ($urandom_range(0, 3))
      0: step = 2;
      1: step = 1000;
      2: step = 1 << 20;
      default: step = 32'hFFFF_FFFF / len;
    endcase
    highest = LONG_MAX - longint'(step) * (len - 1);
    if (highest < LONG_MIN) highest = LONG_MIN;
    if ($urandom_range(0, 4) == 0) begin
      cur = LONG_MIN;
    end else begin
      span = highest - LONG_MIN + 1;
      r    = {$urandom, $urandom};
      cur  = LONG_MIN + longint'(r % span);
    end
    for (i = 0; i < len; i++) begin
      if (cur > LONG_MAX) cur = LONG_MAX;
      send_item(make_write(base + i, cur[bst_pkg::DATA_WIDTH-1:0]));
      cur = cur + longint'($urandom_range(0, step));
    end
  endtask

  // Searches mostly inside the written run [rb, re]; a search that would probe
  // an unwritten entry is narrowed to a single entry of the run.
  task automatic run_searches(input int rb, input int re, input int n);
    bst_pkg::in_t                          c;
    bst_pkg::out_t                         unused;
    bit                                    clean;
    int                                    lo;
    int                                    hi;
    int                                    k;
    int                                    j;
    logic signed [bst_pkg::DATA_WIDTH-1:0] key;
    for (j = 0; j < n; j++) begin
      case ($urandom_range(0, 9))
        0: begin
          lo = $urandom_range(0, bst_pkg::DEPTH - 1);
          hi = $urandom_range(lo, bst_pkg::DEPTH - 1);
        end
        1: begin
          hi = $urandom_range(rb, re);
          lo = $urandom_range(hi, re);
        end
        default: begin
          lo = $urandom_range(rb, re);
          hi = $urandom_range(lo, re);
        end
      endcase
      k = (lo <= hi) ? $urandom_range(lo, hi) : $urandom_range(rb, re);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: key = sb.entries[k];
        5: key = sb.entries[k] + 1;
        6: key = sb.entries[k] - 1;
        7: key = $urandom;
        8: key = $urandom_range(0, 1) ? WORD_MIN : WORD_MAX;
        default: key = sb.entries[lo] - 1;
      endcase
      if (^key === 1'bx) key = $urandom;
      c = make_search(key, lo, hi);
      unused = sb.predict(c, clean);
      if (!clean) begin
        k = $urandom_range(rb, re);
        c = make_search(key, k, k);
      end
      send_item(c);
    end
  endtask

  task automatic run_directed();
    send_item(make_write(0, WORD_MIN));
    send_item(make_write(1, -100));
    send_item(make_write(2, 0));
    send_item(make_write(3, 5));
    send_item(make_write(4, 77));
    send_item(make_write(5, WORD_MAX));
    send_item(make_write(bst_pkg::DEPTH - 2, -5));
    send_item(make_write(bst_pkg::DEPTH - 1, WORD_MAX));
    send_item(make_search(0, 0, 5));
    send_item(make_search(WORD_MIN, 0, 5));
    send_item(make_search(WORD_MAX, 0, 5));
    // Keys beyond the end values of the range stop after one comparison.
    send_item(make_search(WORD_MIN, 1, 5));
    send_item(make_search(WORD_MAX, 0, 4));
    send_item(make_search(3, 0, 5));
    send_item(make_search(5, 0, 5));
    send_item(make_search(0, 5, 2));
    send_item(make_search(5, 3, 3));
    send_item(make_search(-5, bst_pkg::DEPTH - 2, bst_pkg::DEPTH - 1));
    send_item(make_search(WORD_MAX, bst_pkg::DEPTH - 2, bst_pkg::DEPTH - 1));
    // Break the order of the table and search it anyway.
    send_item(make_write(2, 1000));
    send_item(make_search(-100, 0, 5));
    send_item(make_search(500, 0, 5));
  endtask

  initial begin
    int base;
    int len;
    int pick;
    int phase;
    sb         = new();
    rst        = 1'b1;
    push       = 1'b0;
    cmd        = '0;
    steady     = 1'b0;
    items_sent = 0;
    phase      = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    wait_drained();

    while (items_sent < ITEM_TARGET) begin
      steady = ($urandom_range(0, 9) == 0);
      pick = $urandom_range(0, 19);
      if (pick < 14) len = $urandom_range(1, 16);
      else if (pick < 19) len = $urandom_range(17, 64);
      else len = $urandom_range(65, 300);
      base = $urandom_range(0, bst_pkg::DEPTH - len);
      load_sorted_run(base, len);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3))
          send_item(make_write($urandom_range(base, base + len - 1), $urandom));
      end
      if ($urandom_range(0, 9) == 0)
        send_item(make_write($urandom_range(0, bst_pkg::DEPTH - 1), $urandom));
      run_searches(base, base + len - 1, $urandom_range(3, 10));
      if (phase % 7 == 3) wait_drained();
      phase++;
    end
    steady = 1'b0;
    @(negedge clk);
    push <= 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.report("expected results left over");
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Result side: draws a stall per item, then takes the oldest waiting result.
  initial begin
    int gap;
    pop = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      gap = draw_gap();
      @(negedge clk);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      sb.check_result(result);
    end
  end

endmodule
